// ===== hdl/octahedron_sphere_mesh_generator_top_defines.svh =====
// ---------------------------------------------------------------------------
// octahedron sphere mesh generator assertion macros
// shared property forms for the block's checker
// ---------------------------------------------------------------------------
`ifndef OCTAHEDRON_SPHERE_MESH_GENERATOR_TOP_DEFINES_SVH
`define OCTAHEDRON_SPHERE_MESH_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define OSMG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define OSMG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/osmg_pkg.sv =====
// ---------------------------------------------------------------------------
// osmg_pkg
// types and constants shared by the sphere mesh generator modules
// ---------------------------------------------------------------------------
`default_nettype none
package osmg_pkg;

  localparam int IDX_W   = 15;
  localparam int CRD_W   = 16;
  localparam int LAT_W   = 9;
  localparam int CFG_W   = 7;
  localparam int Q_DEPTH = 2;

  localparam logic [1:0] KIND_VERT = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        index;
    logic signed [LAT_W-1:0] lat_x;
    logic signed [LAT_W-1:0] lat_y;
    logic signed [LAT_W-1:0] lat_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
    logic                    last;
  } osmg_cmd_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        index;
    logic signed [CRD_W-1:0] coord_x;
    logic signed [CRD_W-1:0] coord_y;
    logic signed [CRD_W-1:0] coord_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
    logic                    mesh_done;
  } osmg_res_t;

endpackage
`default_nettype wire

// ===== hdl/osmg_front.sv =====
// ---------------------------------------------------------------------------
// osmg_front
// walks octants, levels and points; turns each tick into a vertex,
// triangle or finished command
// ---------------------------------------------------------------------------
`default_nettype none
module osmg_front import osmg_pkg::*; #(
  parameter int MAX_LEVELS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire logic             tick,
  input  wire logic             restart,
  output osmg_cmd_t             cmd
);

  localparam int LW = $clog2(MAX_LEVELS + 2);
  localparam logic [7:0] MAXL8 = 8'(MAX_LEVELS);

  typedef enum logic [1:0] {PH_VERT, PH_TRI, PH_DONE} phase_t;

  logic [CFG_W-1:0] num_levels_r;
  phase_t           phase_r, phase_nxt, ph;
  logic [2:0]       oct_r, oct_nxt, oc;
  logic [LW-1:0]    level_r, level_nxt, lv;
  logic [LW-1:0]    point_r, point_nxt, pt;
  logic             below_r, below_nxt, bl;
  logic [IDX_W-1:0] vcnt_r, vcnt_nxt, vc;
  logic [IDX_W-1:0] tcnt_r, tcnt_nxt, tc;
  logic [IDX_W-1:0] base_r, base_nxt, bs;

  logic [7:0]              lclamp;
  logic [LW-1:0]           eff_l;
  logic signed [LAT_W-1:0] ls, ps, ys;
  logic [2*LW-1:0]         tri_prod;
  logic [IDX_W-1:0]        vi;
  logic [LW:0]             pt_inc, lv_inc;

  always_comb begin
    lclamp = {1'b0, num_levels_r};
    if (lclamp == 8'd0) lclamp = 8'd1;
    if (lclamp > MAXL8) lclamp = MAXL8;
    eff_l = LW'(lclamp);
  end

  always_comb begin
    ph = restart ? PH_VERT : phase_r;
    oc = restart ? 3'd0 : oct_r;
    lv = restart ? '0 : level_r;
    pt = restart ? '0 : point_r;
    bl = restart ? 1'b0 : below_r;
    vc = restart ? '0 : vcnt_r;
    tc = restart ? '0 : tcnt_r;
    bs = restart ? '0 : base_r;

    phase_nxt = ph;
    oct_nxt   = oc;
    level_nxt = lv;
    point_nxt = pt;
    below_nxt = bl;
    vcnt_nxt  = vc;
    tcnt_nxt  = tc;
    base_nxt  = bs;
    cmd       = '0;

    ls       = LAT_W'(lv);
    ps       = LAT_W'(pt);
    ys       = LAT_W'(eff_l) - ls;
    tri_prod = (2*LW)'(lv) * (2*LW)'({1'b0, lv} + 1'b1);
    vi       = bs + IDX_W'(tri_prod >> 1) + IDX_W'(pt);
    pt_inc   = {1'b0, pt} + 1'b1;
    lv_inc   = {1'b0, lv} + 1'b1;

    unique case (ph)
      PH_VERT: begin
        cmd.kind  = KIND_VERT;
        cmd.index = vc;
        cmd.lat_y = oc[2] ? -ys : ys;
        case (oc[1:0])
          2'd0: begin
            cmd.lat_x = ps;
            cmd.lat_z = ls - ps;
          end
          2'd1: begin
            cmd.lat_x = ls - ps;
            cmd.lat_z = -ps;
          end
          2'd2: begin
            cmd.lat_x = -ps;
            cmd.lat_z = ps - ls;
          end
          default: begin
            cmd.lat_x = ps - ls;
            cmd.lat_z = ps;
          end
        endcase
        vcnt_nxt  = vc + 1'b1;
        point_nxt = pt_inc[LW-1:0];
        if (pt_inc > {1'b0, lv}) begin
          point_nxt = '0;
          level_nxt = lv_inc[LW-1:0];
          if (lv_inc > {1'b0, eff_l}) begin
            phase_nxt = PH_TRI;
            level_nxt = LW'(1);
            below_nxt = 1'b0;
          end
        end
      end
      PH_TRI: begin
        cmd.kind     = KIND_TRI;
        cmd.index    = tc;
        cmd.corner_a = vi;
        cmd.corner_b = vi + 1'b1;
        tcnt_nxt     = tc + 1'b1;
        if (bl) begin
          cmd.corner_c = vi + IDX_W'(lv) + IDX_W'(2);
          below_nxt    = 1'b0;
        end else begin
          cmd.corner_c = vi - IDX_W'(lv);
          if (lv < eff_l) below_nxt = 1'b1;
        end
        if (bl || !(lv < eff_l)) begin
          point_nxt = pt_inc[LW-1:0];
          if (pt_inc >= {1'b0, lv}) begin
            point_nxt = '0;
            level_nxt = lv_inc[LW-1:0];
            if (lv_inc > {1'b0, eff_l}) begin
              oct_nxt   = oc + 1'b1;
              base_nxt  = vc;
              level_nxt = '0;
              if (oc == 3'd7) begin
                phase_nxt = PH_DONE;
                cmd.last  = 1'b1;
              end else begin
                phase_nxt = PH_VERT;
              end
            end
          end
        end
      end
      default: begin
        cmd.kind = KIND_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r <= CFG_W'(4);
      phase_r      <= PH_VERT;
      oct_r        <= '0;
      level_r      <= '0;
      point_r      <= '0;
      below_r      <= 1'b0;
      vcnt_r       <= '0;
      tcnt_r       <= '0;
      base_r       <= '0;
    end else begin
      if (cfg_wr_en) num_levels_r <= cfg_wr_data;
      if (tick) begin
        phase_r <= phase_nxt;
        oct_r   <= oct_nxt;
        level_r <= level_nxt;
        point_r <= point_nxt;
        below_r <= below_nxt;
        vcnt_r  <= vcnt_nxt;
        tcnt_r  <= tcnt_nxt;
        base_r  <= base_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/osmg_fifo.sv =====
// ---------------------------------------------------------------------------
// osmg_fifo
// short command queue between the sequencer and the normalizer
// ---------------------------------------------------------------------------
`default_nettype none
module osmg_fifo import osmg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  osmg_cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output osmg_cmd_t rd_data,
  output logic      rd_valid
);

  localparam int PW = $clog2(Q_DEPTH);

  osmg_cmd_t     mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r;

  assign full     = (cnt_r == (PW+1)'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/osmg_back.sv =====
// ---------------------------------------------------------------------------
// osmg_back
// normalizes vertex lattice points to q1.14 by a bitwise root search
// and holds the result register
// ---------------------------------------------------------------------------
`default_nettype none
module osmg_back import osmg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  osmg_cmd_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output osmg_res_t res
);

  localparam int SQ_W  = 2*LAT_W - 3;
  localparam int SUM_W = SQ_W + 1;
  localparam int N_W   = 15;
  localparam int T_W   = N_W + 1;
  localparam int P_W   = 2*T_W + SUM_W;

  typedef enum logic [2:0] {B_IDLE, B_PREP, B_SQ, B_CMP, B_OUT} bstate_t;

  bstate_t                   st_r;
  osmg_cmd_t                 cmd_r;
  logic [SUM_W-1:0]          sum_r;
  logic [SQ_W-1:0]           sq_r  [3];
  logic [N_W-1:0]            n_r   [3];
  logic [2*T_W-1:0]          t2_r  [3];
  logic [3:0]                bit_r;
  logic                      out_valid_r;
  osmg_res_t                 res_r;

  logic signed [LAT_W-1:0]   lat   [3];
  logic signed [2*LAT_W-1:0] sqf   [3];
  logic [N_W-1:0]            trial [3];
  logic [T_W-1:0]            tv    [3];
  logic [P_W-1:0]            lhs   [3];
  logic [CRD_W-1:0]          crd   [3];
  logic                      load;

  assign q_pop     = (st_r == B_IDLE) && q_valid;
  assign load      = (st_r == B_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    lat[0] = cmd_r.lat_x;
    lat[1] = cmd_r.lat_y;
    lat[2] = cmd_r.lat_z;
    for (int k = 0; k < 3; k++) begin
      sqf[k]   = lat[k] * lat[k];
      trial[k] = n_r[k] | (N_W'(1) << bit_r);
      tv[k]    = {trial[k], 1'b0} - 1'b1;
      lhs[k]   = P_W'(t2_r[k]) * P_W'(sum_r);
      if (sum_r == '0) crd[k] = '0;
      else if (lat[k] < 0) crd[k] = -CRD_W'(n_r[k]);
      else crd[k] = CRD_W'(n_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_data;
            st_r  <= (q_data.kind == KIND_VERT) ? B_PREP : B_OUT;
          end
        end
        B_PREP: begin
          for (int k = 0; k < 3; k++) begin
            sq_r[k] <= sqf[k][SQ_W-1:0];
            n_r[k]  <= '0;
          end
          sum_r <= SUM_W'(sqf[0][SQ_W-1:0]) + SUM_W'(sqf[1][SQ_W-1:0])
                 + SUM_W'(sqf[2][SQ_W-1:0]);
          bit_r <= 4'(N_W - 1);
          st_r  <= B_SQ;
        end
        B_SQ: begin
          for (int k = 0; k < 3; k++) t2_r[k] <= tv[k] * tv[k];
          st_r <= B_CMP;
        end
        B_CMP: begin
          for (int k = 0; k < 3; k++) begin
            if (lhs[k] <= {sq_r[k], (P_W-SQ_W)'(0)} >> (P_W-SQ_W-30)) n_r[k] <= trial[k];
          end
          if (bit_r == 4'd0) st_r <= B_OUT;
          else begin
            bit_r <= bit_r - 1'b1;
            st_r  <= B_SQ;
          end
        end
        B_OUT: begin
          if (load) begin
            res_r.kind      <= cmd_r.kind;
            res_r.index     <= (cmd_r.kind == KIND_DONE) ? '0 : cmd_r.index;
            res_r.coord_x   <= (cmd_r.kind == KIND_VERT) ? crd[0] : '0;
            res_r.coord_y   <= (cmd_r.kind == KIND_VERT) ? crd[1] : '0;
            res_r.coord_z   <= (cmd_r.kind == KIND_VERT) ? crd[2] : '0;
            res_r.corner_a  <= cmd_r.corner_a;
            res_r.corner_b  <= cmd_r.corner_b;
            res_r.corner_c  <= cmd_r.corner_c;
            res_r.mesh_done <= cmd_r.last;
            st_r            <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/octahedron_sphere_mesh_generator_top.sv =====
// ---------------------------------------------------------------------------
// octahedron_sphere_mesh_generator_top
// sphere mesh generator over eight subdivided octahedron faces
// ---------------------------------------------------------------------------
// Each input transfer is one tick and yields exactly one output transfer: a
// vertex, a triangle, or a finished marker. A sequencer classifies the tick at
// once and pushes a command into a two-entry queue; the back end then builds
// the result. A vertex goes through the q1.14 normalizer, which searches the
// 15 result bits one at a time (square, then multiply and compare) for all
// three coordinates in parallel. Triangles and finished markers bypass the
// normalizer. The queue and the output register let ticks be accepted while
// a finished result waits to be taken.
`default_nettype none
module octahedron_sphere_mesh_generator_top import osmg_pkg::*; #(
  parameter int MAX_LEVELS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // restart
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // item_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
  output logic [111:0]          out_tdata,
  output logic [1:0]            out_tuser,  // item_kind
  output logic                  out_tlast   // mesh_done
);

  osmg_cmd_t fr_cmd, q_cmd;
  osmg_res_t res;
  logic      q_full, q_valid, q_pop, tick;

  assign in_tready = !q_full;
  assign tick      = in_tvalid && in_tready;

  osmg_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick        (tick),
    .restart     (in_tdata[0]),
    .cmd         (fr_cmd)
  );

  osmg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tick),
    .wr_data  (fr_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_cmd),
    .rd_valid (q_valid)
  );

  osmg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {4'd0, res.corner_c, res.corner_b, res.corner_a,
                      res.coord_z, res.coord_y, res.coord_x, res.index};
  assign out_tuser = res.kind;
  assign out_tlast = res.mesh_done;

endmodule
`default_nettype wire

// ===== hdl/osmg_checker.sv =====
// ---------------------------------------------------------------------------
// osmg_checker
// port-level checks on the generator's result stream
// ---------------------------------------------------------------------------
`default_nettype none
`include "octahedron_sphere_mesh_generator_top_defines.svh"
module osmg_checker import osmg_pkg::*; (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [111:0] out_tdata,
  input wire logic [1:0]   out_tuser,
  input wire logic         out_tlast
);

  `OSMG_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `OSMG_ASSERT_IMPL(a_last_tri, out_tvalid && out_tlast, out_tuser == KIND_TRI, "mesh end not on a triangle")
  `OSMG_ASSERT_IMPL(a_vert_nocorner, out_tvalid && out_tuser == KIND_VERT, out_tdata[107:63] == '0, "vertex carries corners")

endmodule

bind octahedron_sphere_mesh_generator_top osmg_checker u_osmg_checker (.*);
`default_nettype wire

// ===== dv/tb_octahedron_sphere_mesh_generator_top.sv =====
// ---------------------------------------------------------------------------
// tb_octahedron_sphere_mesh_generator_top
// tick-stream test of the octahedron sphere mesh generator
// ---------------------------------------------------------------------------
// Every tick is mirrored into a local mesh walker that predicts the next
// vertex, triangle or finished marker. Each result transfer is compared field
// by field with the oldest prediction. Directed runs cover the default level
// count, a whole single-level mesh, level clamping and restart. They are
// followed by random runs at many level counts, with random gaps on both sides.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_octahedron_sphere_mesh_generator_top import osmg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEVELS = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;

  typedef enum logic [1:0] {WALK_VERT, WALK_TRI, WALK_DONE} walk_phase_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [111:0]     out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;

  octahedron_sphere_mesh_generator_top #(.MAX_LEVELS(MAX_LEVELS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // walker state
  logic [6:0]  level_reg;
  logic [2:0]  octant;
  walk_phase_t walk_phase;
  int          level_i;
  int          point_i;
  bit          apex_below;
  logic [14:0] vert_total;
  logic [15:0] tri_total;
  logic [14:0] octant_first;

  osmg_res_t pending_items[$];
  int        mismatch_count;
  int        stall_cycles;
  bit        ready_busy;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] to_q14(int a, longint unsigned s);
    longint unsigned mag, rhs, lo, hi, mid, t;
    mag = (a < 0) ? -a : a;
    rhs = (32768 * mag) * (32768 * mag);
    lo = 0;
    hi = 16384;
    if (s == 0) return 16'd0;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (a < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  function automatic void walker_clear();
    octant = 0;
    walk_phase = WALK_VERT;
    level_i = 0;
    point_i = 0;
    apex_below = 0;
    vert_total = 0;
    tri_total = 0;
    octant_first = 0;
  endfunction

  function automatic osmg_res_t mesh_step(bit restart);
    osmg_res_t r;
    int lv, dx, dz, rx, rz, vx, vy, vz;
    longint unsigned s;
    int unsigned base_i;
    lv = (level_reg < 1) ? 1 : (level_reg > MAX_LEVELS) ? MAX_LEVELS : level_reg;
    if (restart) walker_clear();
    r = '0;
    if (walk_phase == WALK_DONE) begin
      r.kind = KIND_DONE;
      return r;
    end
    if (walk_phase == WALK_VERT) begin
      case (octant[1:0])
        2'd0: begin dx = 0;  dz = 1;  rx = 1;  rz = -1; end
        2'd1: begin dx = 1;  dz = 0;  rx = -1; rz = -1; end
        2'd2: begin dx = 0;  dz = -1; rx = -1; rz = 1;  end
        default: begin dx = -1; dz = 0; rx = 1; rz = 1; end
      endcase
      vx = level_i * dx + point_i * rx;
      vy = (octant < 4) ? (lv - level_i) : (level_i - lv);
      vz = level_i * dz + point_i * rz;
      s = vx * vx + vy * vy + vz * vz;
      r.kind = KIND_VERT;
      r.index = vert_total;
      r.coord_x = to_q14(vx, s);
      r.coord_y = to_q14(vy, s);
      r.coord_z = to_q14(vz, s);
      vert_total++;
      point_i++;
      if (point_i > level_i) begin
        point_i = 0;
        level_i++;
        if (level_i > lv) begin
          walk_phase = WALK_TRI;
          level_i = 1;
          apex_below = 0;
        end
      end
      return r;
    end
    base_i = octant_first + level_i * (level_i + 1) / 2 + point_i;
    r.kind = KIND_TRI;
    r.index = tri_total[14:0];
    r.corner_a = 15'(base_i);
    r.corner_b = 15'(base_i + 1);
    tri_total++;
    if (apex_below) begin
      r.corner_c = 15'(base_i + level_i + 2);
      apex_below = 0;
    end else begin
      r.corner_c = 15'(base_i - level_i);
      if (level_i < lv) begin
        apex_below = 1;
        return r;
      end
    end
    point_i++;
    if (point_i >= level_i) begin
      point_i = 0;
      level_i++;
      if (level_i > lv) begin
        octant++;
        octant_first = vert_total;
        level_i = 0;
        if (octant == 0) begin
          walk_phase = WALK_DONE;
          r.mesh_done = 1'b1;
        end else begin
          walk_phase = WALK_VERT;
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_tick(bit restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {7'd0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_items.push_back(mesh_step(restart));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_levels(logic [6:0] value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    level_reg = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic test_default_levels();
    repeat (12) send_tick(1'b0);
  endtask

  task automatic test_single_level_mesh();
    set_levels(7'd1);
    send_tick(1'b1);
    repeat (34) send_tick(1'b0);
  endtask

  task automatic test_level_clamp();
    set_levels(7'd0);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    set_levels(7'd127);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
  endtask

  task automatic test_random_meshes();
    int sent, n, lv, odds;
    sent = 0;
    while (sent < 590) begin
      case ($urandom_range(0, 9))
        0: lv = 0;
        1: lv = 1;
        2, 3: lv = 2;
        4, 5: lv = 3;
        6: lv = 4;
        7: lv = 127;
        8: lv = 64;
        default: lv = $urandom_range(5, 127);
      endcase
      set_levels(7'(lv));
      n = (lv <= 2) ? $urandom_range(40, 100) : $urandom_range(20, 90);
      odds = (lv <= 2) ? 100 : 40;
      send_tick($urandom_range(0, 1));
      repeat (n) send_tick($urandom_range(0, odds - 1) == 0);
      sent += n + 1;
    end
  endtask

  initial begin
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    rst_n = 1'b0;
    level_reg = 7'd4;
    mismatch_count = 0;
    walker_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_default_levels();
    test_single_level_mesh();
    test_level_clamp();
    test_random_meshes();
    drain();
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // result-side backpressure
  initial begin
    int run;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        ready_busy = ($urandom_range(0, 2) == 0);
        run = ready_busy ? pick_gap() : $urandom_range(1, 30);
      end
      out_tready = !ready_busy;
      if (run > 0) run--;
    end
  end

  always @(posedge clk) begin
    osmg_res_t want;
    osmg_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.kind = out_tuser;
      got.index = out_tdata[14:0];
      got.coord_x = out_tdata[30:15];
      got.coord_y = out_tdata[46:31];
      got.coord_z = out_tdata[62:47];
      got.corner_a = out_tdata[77:63];
      got.corner_b = out_tdata[92:78];
      got.corner_c = out_tdata[107:93];
      got.mesh_done = out_tlast;
      if (pending_items.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected transfer %p", got);
      end else begin
        want = pending_items.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch exp %p act %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
`default_nettype wire
